/* hdl/oawt_pkg.sv */
// ============================================================================
// oawt_pkg - shared definitions for the open addressing word table
// Constants, status and register codes, configuration struct, helpers.
// ============================================================================
`default_nettype none

package oawt_pkg;

    localparam int TABLE_DEPTH_DEF  = 256;
    localparam int MAX_WORD_LEN_DEF = 16;
    localparam int QUEUE_DEPTH      = 2;
    localparam int HASH_W           = 64;
    localparam int CFG_DATA_W       = 9;
    localparam int CFG_INDEX_W      = 2;

    localparam logic [HASH_W-1:0] HASH_SEED = 64'd5381;

    // result status codes
    localparam logic [2:0] ST_FULL    = 3'd0;
    localparam logic [2:0] ST_NEW     = 3'd1;
    localparam logic [2:0] ST_PRESENT = 3'd2;
    localparam logic [2:0] ST_FOUND   = 3'd3;
    localparam logic [2:0] ST_MISSING = 3'd4;
    localparam logic [2:0] ST_TOOLONG = 3'd5;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_TABLE_SIZE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PROBE_MODE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_MULT  = 2'd2;

    // probe modes (any other code probes linearly)
    localparam logic [1:0] PM_LINEAR = 2'd0;
    localparam logic [1:0] PM_QUAD   = 2'd1;
    localparam logic [1:0] PM_DOUBLE = 2'd2;

    // operations
    localparam logic OP_INSERT = 1'b0;

    typedef struct packed {
        logic [8:0] table_size;
        logic [1:0] probe_mode;
        logic [7:0] step_multiplier;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic clearing;
    } back_stat_t;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

`default_nettype wire

/* hdl/oawt_if.sv */
// ============================================================================
// oawt_if - channel interfaces for the word table
// Letter input channel and result output channel, valid/ready handshake.
// ============================================================================
`default_nettype none

interface oawt_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] letter;
    logic       last_letter;

    modport source (output valid, output operation, output letter, output last_letter,
                    input ready);
    modport sink   (input valid, input operation, input letter, input last_letter,
                    output ready);
endinterface

interface oawt_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  slot;
    logic [8:0]  probe_collisions;
    logic [31:0] total_words;
    logic [31:0] unique_words;
    logic [31:0] total_collisions;

    modport source (output valid, output status, output slot, output probe_collisions,
                    output total_words, output unique_words, output total_collisions,
                    input ready);
    modport sink   (input valid, input status, input slot, input probe_collisions,
                    input total_words, input unique_words, input total_collisions,
                    output ready);
endinterface

`default_nettype wire

/* hdl/oawt_fifo.sv */
// ============================================================================
// oawt_fifo - job queue between front and back
// Small register queue; decouples letter intake from the probe engine.
// ============================================================================
`default_nettype none

module oawt_fifo #(
    parameter int W = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [W-1:0]      wdata,
    input  wire logic              pop,
    output logic [W-1:0]           rdata,
    output oawt_pkg::q_stat_t      qstat
);
    import oawt_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [W-1:0]  mem_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign rdata       = mem_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == CW'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/oawt_front.sv */
// ============================================================================
// oawt_front - letter intake and hashing
// Accepts letters, runs the djb2 hash, buffers the word, queues word jobs.
// ============================================================================
`default_nettype none

module oawt_front #(
    parameter  int MAX_WORD_LEN = oawt_pkg::MAX_WORD_LEN_DEF,
    localparam int LW = $clog2(MAX_WORD_LEN + 1),
    localparam int JW = 2 + LW + oawt_pkg::HASH_W + 8 * MAX_WORD_LEN
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    oawt_in_if.sink                 in_ch,
    input  oawt_pkg::back_stat_t    bstat,
    input  oawt_pkg::q_stat_t       qstat,
    output logic                    push,
    output logic [JW-1:0]           job
);
    import oawt_pkg::*;

    localparam int CW = $clog2(MAX_WORD_LEN + 2);
    localparam int IW = $clog2(MAX_WORD_LEN);
    localparam int KW = 8 * MAX_WORD_LEN;

    logic [HASH_W-1:0] hash_reg, hash_next, hash_step;
    logic [CW-1:0]     len_reg, len_next, len_inc;
    logic [KW-1:0]     buf_reg, buf_next;
    logic              accept, too_long;

    assign in_ch.ready = !bstat.clearing && !qstat.full;
    assign accept      = in_ch.valid && in_ch.ready;

    // h * 33 + c, wrapping
    assign hash_step = (hash_reg << 5) + hash_reg + {{(HASH_W-8){1'b0}}, in_ch.letter};
    assign len_inc   = (len_reg <= CW'(MAX_WORD_LEN)) ? len_reg + 1'b1 : len_reg;
    assign too_long  = (len_inc > CW'(MAX_WORD_LEN));

    always_comb
    begin
        buf_next = buf_reg;
        if (len_reg < CW'(MAX_WORD_LEN))
        begin
            buf_next[len_reg[IW-1:0] * 8 +: 8] = in_ch.letter;
        end
        hash_next = hash_reg;
        len_next  = len_reg;
        if (accept)
        begin
            hash_next = in_ch.last_letter ? HASH_SEED : hash_step;
            len_next  = in_ch.last_letter ? '0 : len_inc;
        end
    end

    assign push = accept && in_ch.last_letter;
    assign job  = {in_ch.operation, too_long, len_inc[LW-1:0], hash_step, buf_next};

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            buf_reg <= buf_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= HASH_SEED;
            len_reg  <= '0;
        end
        else
        begin
            hash_reg <= hash_next;
            len_reg  <= len_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/oawt_back.sv */
// ============================================================================
// oawt_back - probe engine
// Serial hash remainders, probe walk over the slot tables, result register.
// ============================================================================
`default_nettype none

module oawt_back #(
    parameter  int TABLE_DEPTH  = oawt_pkg::TABLE_DEPTH_DEF,
    parameter  int MAX_WORD_LEN = oawt_pkg::MAX_WORD_LEN_DEF,
    localparam int LW = $clog2(MAX_WORD_LEN + 1),
    localparam int JW = 2 + LW + oawt_pkg::HASH_W + 8 * MAX_WORD_LEN
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  oawt_pkg::cfg_t          cfg,
    input  oawt_pkg::q_stat_t       qstat,
    input  wire logic [JW-1:0]      job,
    output logic                    pop,
    output oawt_pkg::back_stat_t    bstat,
    oawt_out_if.source              out_ch
);
    import oawt_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = $clog2(TABLE_DEPTH + 1);
    localparam int PW = AW + 2;
    localparam int KW = 8 * MAX_WORD_LEN;

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_DIV, S_SMOD, S_RD, S_EV} state_t;

    state_t            state_reg;
    logic [AW-1:0]     clr_addr_reg;
    logic              op_reg;
    logic [LW-1:0]     len_reg;
    logic [HASH_W-1:0] hash_reg;
    logic [KW-1:0]     key_reg;
    logic [NW-1:0]     n_reg, i_reg;
    logic [7:0]        a_reg, ra_reg, step_reg;
    logic [1:0]        mode_reg;
    logic [5:0]        bit_reg;
    logic [AW-1:0]     addr_reg, delta_reg;

    logic        out_valid_reg;
    logic [2:0]  out_status_reg;
    logic [7:0]  out_slot_reg;
    logic [8:0]  out_coll_reg;
    logic [31:0] words_reg, uniq_reg, coll_reg;

    // slot tables
    logic [LW:0]   tag_mem [TABLE_DEPTH];
    logic [KW-1:0] key_mem [TABLE_DEPTH];
    logic [LW:0]   tag_rd;
    logic [KW-1:0] key_rd;
    logic          tag_we, key_we;
    logic [AW-1:0] waddr;
    logic [LW:0]   tag_wdata;

    // combinational helpers
    logic [NW-1:0] n_eff, i_inc;
    logic [7:0]    a_eff;
    logic [PW-1:0] rn_sh, rn_red, sm_sh, sm_red, adv_sum, adv_red, dq_sum, dq_red1, dq_red2;
    logic [PW-1:0] n_ext;
    logic [8:0]    ra_sh, ra_red;
    logic          occ, match, insert_free;
    logic [AW-1:0] one_mod_n;
    logic [31:0]   slot32, idx32, n32, coll_add;

    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[waddr] <= tag_wdata;
        end
        if (key_we)
        begin
            key_mem[waddr] <= key_reg;
        end
        tag_rd <= tag_mem[addr_reg];
        key_rd <= key_mem[addr_reg];
    end

    always_comb
    begin
        if (cfg.table_size == '0)
        begin
            n_eff = NW'(1);
        end
        else if (32'(cfg.table_size) > 32'(TABLE_DEPTH))
        begin
            n_eff = NW'(TABLE_DEPTH);
        end
        else
        begin
            n_eff = NW'(cfg.table_size);
        end
    end

    assign a_eff     = (cfg.step_multiplier == '0) ? 8'd1 : cfg.step_multiplier;
    assign n_ext     = PW'(n_reg);
    assign one_mod_n = (n_reg == NW'(1)) ? '0 : AW'(1);

    // one restoring remainder bit per cycle, for hash mod n, hash mod a and step mod n
    assign rn_sh  = {1'b0, addr_reg, hash_reg[HASH_W-1]};
    assign rn_red = (rn_sh >= n_ext) ? rn_sh - n_ext : rn_sh;
    assign ra_sh  = {ra_reg, hash_reg[HASH_W-1]};
    assign ra_red = (ra_sh >= {1'b0, a_reg}) ? ra_sh - {1'b0, a_reg} : ra_sh;
    assign sm_sh  = {1'b0, delta_reg, step_reg[7]};
    assign sm_red = (sm_sh >= n_ext) ? sm_sh - n_ext : sm_sh;

    // next probe address and quadratic increment
    assign adv_sum = PW'(addr_reg) + PW'(delta_reg);
    assign adv_red = (adv_sum >= n_ext) ? adv_sum - n_ext : adv_sum;
    assign dq_sum  = PW'(delta_reg) + PW'(2);
    assign dq_red1 = (dq_sum >= n_ext) ? dq_sum - n_ext : dq_sum;
    assign dq_red2 = (dq_red1 >= n_ext) ? dq_red1 - n_ext : dq_red1;

    assign i_inc = i_reg + 1'b1;
    assign occ   = tag_rd[LW];

    always_comb
    begin
        match = occ && (tag_rd[LW-1:0] == len_reg);
        for (int k = 0; k < MAX_WORD_LEN; k++)
        begin
            if ((32'(k) < 32'(len_reg)) && (key_rd[k*8 +: 8] != key_reg[k*8 +: 8]))
            begin
                match = 1'b0;
            end
        end
    end

    assign insert_free = (state_reg == S_EV) && !occ && (op_reg == OP_INSERT);

    assign tag_we    = (state_reg == S_CLEAR) || insert_free;
    assign key_we    = insert_free;
    assign waddr     = (state_reg == S_CLEAR) ? clr_addr_reg : addr_reg;
    assign tag_wdata = (state_reg == S_CLEAR) ? '0 : {1'b1, len_reg};

    assign slot32   = 32'(addr_reg);
    assign idx32    = 32'(i_reg);
    assign n32      = 32'(n_reg);
    assign coll_add = (occ && !match) ? n32 : idx32;

    assign pop            = (state_reg == S_IDLE) && !qstat.empty && !out_valid_reg;
    assign bstat.clearing = (state_reg == S_CLEAR);

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.status           = out_status_reg;
    assign out_ch.slot             = out_slot_reg;
    assign out_ch.probe_collisions = out_coll_reg;
    assign out_ch.total_words      = words_reg;
    assign out_ch.unique_words     = uniq_reg;
    assign out_ch.total_collisions = coll_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
            words_reg     <= '0;
            uniq_reg      <= '0;
            coll_reg      <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == AW'(TABLE_DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (pop)
                    begin
                        key_reg  <= job[KW-1:0];
                        hash_reg <= job[KW +: HASH_W];
                        len_reg  <= job[KW+HASH_W +: LW];
                        op_reg   <= job[KW+HASH_W+LW+1];
                        n_reg    <= n_eff;
                        a_reg    <= a_eff;
                        mode_reg <= cfg.probe_mode;
                        addr_reg <= '0;
                        ra_reg   <= '0;
                        bit_reg  <= 6'(HASH_W - 1);
                        if (job[KW+HASH_W+LW])
                        begin
                            out_valid_reg  <= 1'b1;
                            out_status_reg <= ST_TOOLONG;
                            out_slot_reg   <= '0;
                            out_coll_reg   <= '0;
                        end
                        else
                        begin
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_DIV:
                begin
                    addr_reg <= rn_red[AW-1:0];
                    ra_reg   <= ra_red[7:0];
                    hash_reg <= hash_reg << 1;
                    if (bit_reg == '0)
                    begin
                        step_reg  <= a_reg - ra_red[7:0];
                        delta_reg <= '0;
                        bit_reg   <= 6'd7;
                        state_reg <= S_SMOD;
                    end
                    else
                    begin
                        bit_reg <= bit_reg - 1'b1;
                    end
                end
                S_SMOD:
                begin
                    step_reg <= step_reg << 1;
                    if (bit_reg == '0)
                    begin
                        // linear and quadratic walks start with a step of one
                        delta_reg <= (mode_reg != PM_DOUBLE) ? one_mod_n : sm_red[AW-1:0];
                        i_reg     <= '0;
                        state_reg <= S_RD;
                    end
                    else
                    begin
                        delta_reg <= sm_red[AW-1:0];
                        bit_reg   <= bit_reg - 1'b1;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_EV;
                end
                S_EV:
                begin
                    if (!occ || match || (i_inc == n_reg))
                    begin
                        state_reg     <= S_IDLE;
                        out_valid_reg <= 1'b1;
                        out_slot_reg  <= (!occ && op_reg != OP_INSERT) || (occ && !match)
                                         ? 8'd0 : slot32[7:0];
                        out_coll_reg  <= coll_add[8:0];
                        if (op_reg == OP_INSERT)
                        begin
                            coll_reg <= sat_add32(coll_reg, coll_add);
                            if (match)
                            begin
                                out_status_reg <= ST_PRESENT;
                                words_reg      <= sat_add32(words_reg, 32'd1);
                            end
                            else if (!occ)
                            begin
                                out_status_reg <= ST_NEW;
                                words_reg      <= sat_add32(words_reg, 32'd1);
                                uniq_reg       <= sat_add32(uniq_reg, 32'd1);
                            end
                            else
                            begin
                                out_status_reg <= ST_FULL;
                            end
                        end
                        else
                        begin
                            out_status_reg <= match ? ST_FOUND : ST_MISSING;
                        end
                    end
                    else
                    begin
                        i_reg     <= i_inc;
                        addr_reg  <= adv_red[AW-1:0];
                        if (mode_reg == PM_QUAD)
                        begin
                            delta_reg <= dq_red2[AW-1:0];
                        end
                        state_reg <= S_RD;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* hdl/open_addressing_word_table_unit.sv */
// ============================================================================
// open_addressing_word_table_unit - djb2 word table with open addressing
// Top level: configuration registers, front, job queue and probe engine.
// ============================================================================
// Usage:
//   in_ch carries one letter per transaction, with operation (0 insert,
//   1 lookup) and last_letter. Only the transaction with last_letter high
//   produces a result on out_ch: status, slot, probe_collisions and the
//   running totals after that word.
//   cfg_we/cfg_index/cfg_data write table_size, probe_mode and
//   step_multiplier; write only while the block is idle.
// Flow:
//   Letters are taken one per cycle while the queue has room and no sweep
//   runs. A word end queues a job (two deep); the engine, once idle with
//   its result register empty, loads it, runs the serial hash remainders,
//   then the step remainder, then per probe a slot read and a compare,
//   and fills the result register. A too-long word skips the probe walk.
// Reset:
//   Totals clear; the occupancy table is swept entry by entry after reset,
//   with in_ch.ready low meanwhile.
// Stall:
//   A result waits in its output register while out_ch.ready is low;
//   letters keep flowing until the job queue fills.
// ============================================================================
`default_nettype none

module open_addressing_word_table_unit #(
    parameter int TABLE_DEPTH  = oawt_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_WORD_LEN = oawt_pkg::MAX_WORD_LEN_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    oawt_in_if.sink                                  in_ch,
    oawt_out_if.source                               out_ch,
    input  wire logic                                cfg_we,
    input  wire logic [oawt_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [oawt_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import oawt_pkg::*;

    localparam int LW = $clog2(MAX_WORD_LEN + 1);
    localparam int JW = 2 + LW + HASH_W + 8 * MAX_WORD_LEN;

    cfg_t       cfg_reg;
    q_stat_t    qstat;
    back_stat_t bstat;
    logic       push, pop;
    logic [JW-1:0] job_in, job_out;

    // configuration registers; writes to an unused index are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.table_size      <= 9'd256;
            cfg_reg.probe_mode      <= PM_LINEAR;
            cfg_reg.step_multiplier <= 8'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TABLE_SIZE: cfg_reg.table_size      <= cfg_data;
                CFG_PROBE_MODE: cfg_reg.probe_mode      <= cfg_data[1:0];
                CFG_STEP_MULT:  cfg_reg.step_multiplier <= cfg_data[7:0];
                default:        cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // letter intake and hashing
    oawt_front #(
        .MAX_WORD_LEN (MAX_WORD_LEN)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .bstat (bstat),
        .qstat (qstat),
        .push  (push),
        .job   (job_in)
    );

    // word jobs waiting for the probe engine
    oawt_fifo #(
        .W (JW)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (job_in),
        .pop   (pop),
        .rdata (job_out),
        .qstat (qstat)
    );

    // probe engine, slot tables and result register
    oawt_back #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .MAX_WORD_LEN (MAX_WORD_LEN)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .qstat  (qstat),
        .job    (job_out),
        .pop    (pop),
        .bstat  (bstat),
        .out_ch (out_ch)
    );

endmodule

`default_nettype wire

/* hdl/oawt_checker.sv */
// ============================================================================
// oawt_checker - port level checks for the word table
// Result consistency and handshake checks, bound to the top level.
// ============================================================================
`default_nettype none

module oawt_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [2:0]  status,
    input wire logic [7:0]  slot,
    input wire logic [8:0]  probe_collisions,
    input wire logic [31:0] total_words,
    input wire logic [31:0] unique_words
);
    import oawt_pkg::*;

    // table sweep blocks intake right after reset
    a_sweep_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !in_ready)
        else $error("intake open during table sweep");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(slot))
        else $error("stalled result changed");

    a_uniq_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> unique_words <= total_words)
        else $error("unique count above word count");

    a_toolong: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_TOOLONG |-> slot == 8'd0 && probe_collisions == 9'd0)
        else $error("too-long result with slot or collisions");

    a_miss_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL || status == ST_MISSING) |-> slot == 8'd0)
        else $error("miss or full result with nonzero slot");

endmodule

bind open_addressing_word_table_unit oawt_checker u_oawt_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_ready         (in_ch.ready),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .status           (out_ch.status),
    .slot             (out_ch.slot),
    .probe_collisions (out_ch.probe_collisions),
    .total_words      (out_ch.total_words),
    .unique_words     (out_ch.unique_words)
);

`default_nettype wire
